>>> design/vehicle_track_table_core_macros.svh
// assertion macros used by the vehicle track table core
`ifndef VEHICLE_TRACK_TABLE_CORE_MACROS_SVH
`define VEHICLE_TRACK_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define VTT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define VTT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/vtt_pkg.sv
// types, codes and constants of the vehicle track table
`timescale 1ns / 1ps
package vtt_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_RESULTS   = 16;
   localparam int RES_W         = $clog2(MAX_RESULTS + 1);
   localparam logic [RES_W-1:0] RES_CAP = RES_W'(MAX_RESULTS);
   localparam logic [13:0] SPEED_TOP = 14'd9999;
   localparam int CSR_AW = 4;

   // event codes
   localparam logic [1:0] EV_FINISHED = 2'd0;
   localparam logic [1:0] EV_SPEED    = 2'd1;
   localparam logic [1:0] EV_NEW      = 2'd2;

   // register indexes
   localparam logic [1:0] REG_MIN_SPEED = 2'd0;
   localparam logic [1:0] REG_JUMP      = 2'd1;
   localparam logic [1:0] REG_TIMEOUT   = 2'd2;
   localparam logic [1:0] REG_RETENTION = 2'd3;

   // register reset values
   localparam logic [13:0] MIN_SPEED_RST = 14'd50;
   localparam logic [13:0] JUMP_RST      = 14'd200;
   localparam logic [31:0] TIMEOUT_RST   = 32'd2000;
   localparam logic [31:0] RETENTION_RST = 32'd10000;

   // chain operations
   typedef logic [1:0] chain_op_type;
   localparam chain_op_type OP_NOP     = 2'd0;
   localparam chain_op_type OP_ROT     = 2'd1;
   localparam chain_op_type OP_COMPACT = 2'd2;
   localparam chain_op_type OP_APPEND  = 2'd3;

   typedef struct packed {
      logic        used;
      logic        active;
      logic [15:0] vehicle_id;
      logic [13:0] cur_speed;
      logic [13:0] top_speed;
      logic [31:0] last_time;
   } slot_type;

   typedef struct packed {
      chain_op_type op;
      slot_type     tail_slot;
      slot_type     new_slot;
   } chain_ctl_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] now_ms;
      logic [13:0] speed_tenths;
      logic        approaching;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic        toward;
      logic [15:0] vehicle_id;
      logic [13:0] reported_speed;
      logic [15:0] direction_count;
      logic        final_item;
   } rsp_type;

endpackage

>>> design/vtt_cell.sv
// one slot of a direction list, shifting towards the head
`timescale 1ns / 1ps
module vtt_cell
   import vtt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  chain_op_type op,
   input  slot_type     new_slot,
   input  slot_type     right_slot,
   input  logic         left_used,
   input  logic         hole_in,
   output slot_type     slot_q,
   output logic         hole_out
);

   logic [1:0] flags_ff, flags_in;
   logic [75:0] data_ff, data_in;
   slot_type   cur, nxt;

   assign cur = slot_type'({flags_ff, data_ff});
   assign slot_q = cur;
   assign hole_out = hole_in | ~cur.used;

   // next content by chain operation
   always_comb begin
      nxt = cur;
      case (op)
         OP_ROT: nxt = right_slot;
         OP_COMPACT: if (hole_in || !cur.used) nxt = right_slot;
         OP_APPEND: if (!cur.used && left_used) nxt = new_slot;
         default: nxt = cur;
      endcase
   end

   assign flags_in = {nxt.used, nxt.active};
   assign data_in = {nxt.vehicle_id, nxt.cur_speed, nxt.top_speed, nxt.last_time};

   // flags
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= 2'b00;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> design/vtt_chain.sv
// row of slot cells holding one direction list
`timescale 1ns / 1ps
module vtt_chain
   import vtt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  chain_ctl_type ctl,
   output slot_type      head_slot,
   output logic          full
);

   slot_type slot_q [SLOTS];
   logic     hole [SLOTS+1];

   assign hole[0] = 1'b0;

   genvar k;
   generate
      for (k = 0; k < SLOTS; k++) begin : g_cell
         slot_type right;
         logic     left_used;
         if (k == SLOTS - 1) begin : g_last
            assign right = (ctl.op == OP_ROT) ? ctl.tail_slot : slot_type'('0);
         end else begin : g_mid
            assign right = slot_q[k+1];
         end
         if (k == 0) begin : g_first
            assign left_used = 1'b1;
         end else begin : g_rest
            assign left_used = slot_q[k-1].used;
         end
         vtt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .op         (ctl.op),
            .new_slot   (ctl.new_slot),
            .right_slot (right),
            .left_used  (left_used),
            .hole_in    (hole[k]),
            .slot_q     (slot_q[k]),
            .hole_out   (hole[k+1])
         );
      end
   endgenerate

   assign head_slot = slot_q[0];
   assign full = slot_q[SLOTS-1].used;

endmodule

>>> design/vehicle_track_table_core.sv
// vehicle track table: sequencer, register port and result staging
//
// Input transactions (req_) carry a speed reading or a cleanup tick; each one
// yields up to 16 result transactions (rsp_), the last with final_item set.
// Items are taken one at a time: req_stall is high until the previous item's
// work is done. A reading rotates its direction's cell row once round, one
// cell a cycle unless paused, then releases the last result. A matched
// vehicle goes straight to that release; a new one first emits its new-vehicle
// result and, unless its list is full, is appended with a speed result. A tick
// rotates the approaching row, then the departing row, then closes the gaps.
// A reading below the minimum speed is taken with no result.
// Each result waits in a one-entry holding stage until the next one is found
// or the walk ends, and is then loaded into the output register.
// While rsp_stall is high the output holds and the walk pauses at the next
// result it finds; nothing is dropped but results past the sixteenth.
// Reset empties both lists, clears ids and counts and restores the register
// defaults; there is no clearing pass. The APB-style port is written and read
// at byte addresses 0, 4, 8 and 12 and is always ready.
`timescale 1ns / 1ps
`include "vehicle_track_table_core_macros.svh"
module vehicle_track_table_core
   import vtt_pkg::*;
#(
   parameter int SLOTS_PER_DIRECTION = SLOTS_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int CW = (SLOTS_PER_DIRECTION > 1) ? $clog2(SLOTS_PER_DIRECTION) : 1;
   localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS_PER_DIRECTION - 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_WALK    = 3'd1;
   localparam logic [2:0] ST_NEWV    = 3'd2;
   localparam logic [2:0] ST_APP     = 3'd3;
   localparam logic [2:0] ST_TICKA   = 3'd4;
   localparam logic [2:0] ST_TICKD   = 3'd5;
   localparam logic [2:0] ST_COMPACT = 3'd6;
   localparam logic [2:0] ST_FLUSH   = 3'd7;

   // registers
   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             searching_ff, searching_in;
   logic [RES_W-1:0] res_cnt_ff, res_cnt_in;
   logic             pend_v_ff, pend_v_in;
   rsp_type          pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [31:0]      now_ff, now_in;
   logic [13:0]      spd_ff, spd_in;
   logic             dir_ff, dir_in;
   logic [15:0]      next_num_ff, next_num_in;
   logic [15:0]      tot_a_ff, tot_a_in;
   logic [15:0]      tot_d_ff, tot_d_in;
   logic [15:0]      new_id_ff, new_id_in;
   logic [13:0]      min_ff, jump_ff;
   logic [31:0]      tmo_ff, ret_ff;

   // chain signals
   chain_ctl_type ctl_a, ctl_d;
   chain_op_type  op_a, op_d;
   slot_type      head_a, head_d, head, tail, new_slot;
   logic          full_a, full_d;

   logic          cur_dir;
   logic [15:0]   total_cur;
   logic [13:0]   diff;
   logic [31:0]   age;
   logic          emit_req, drop, out_free, can_take, step, match_now;
   logic          out_load;
   rsp_type       emit_data, out_data;
   logic [13:0]   req_spd;
   logic          req_acc;

   // register port
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_SPEED_RST;
         jump_ff <= JUMP_RST;
         tmo_ff <= TIMEOUT_RST;
         ret_ff <= RETENTION_RST;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_MIN_SPEED: min_ff <= pwdata[13:0];
            REG_JUMP: jump_ff <= pwdata[13:0];
            REG_TIMEOUT: tmo_ff <= pwdata;
            REG_RETENTION: ret_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_MIN_SPEED: prdata = {18'd0, min_ff};
         REG_JUMP: prdata = {18'd0, jump_ff};
         REG_TIMEOUT: prdata = tmo_ff;
         REG_RETENTION: prdata = ret_ff;
         default: prdata = 32'd0;
      endcase
   end

   // direction lists
   assign ctl_a = '{op: op_a, tail_slot: tail, new_slot: new_slot};
   assign ctl_d = '{op: op_d, tail_slot: tail, new_slot: new_slot};

   vtt_chain #(.SLOTS(SLOTS_PER_DIRECTION)) u_chain_a (
      .clock(clock), .reset(reset), .ctl(ctl_a), .head_slot(head_a), .full(full_a)
   );
   vtt_chain #(.SLOTS(SLOTS_PER_DIRECTION)) u_chain_d (
      .clock(clock), .reset(reset), .ctl(ctl_d), .head_slot(head_d), .full(full_d)
   );

   // head comparison
   assign cur_dir = (state_ff == ST_TICKA) ? 1'b1 :
                    (state_ff == ST_TICKD) ? 1'b0 : dir_ff;
   assign head = cur_dir ? head_a : head_d;
   assign total_cur = cur_dir ? tot_a_ff : tot_d_ff;
   assign diff = (head.cur_speed > spd_ff) ? head.cur_speed - spd_ff
                                           : spd_ff - head.cur_speed;
   assign age = now_ff - head.last_time;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc = req_valid && !req_stall;
   assign req_spd = (req_data.speed_tenths > SPEED_TOP) ? SPEED_TOP : req_data.speed_tenths;

   assign drop = (res_cnt_ff >= RES_CAP);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_take = !pend_v_ff || out_free;
   assign step = !emit_req || drop || can_take;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      searching_in = searching_ff;
      res_cnt_in = res_cnt_ff;
      pend_v_in = pend_v_ff;
      pend_in = pend_ff;
      now_in = now_ff;
      spd_in = spd_ff;
      dir_in = dir_ff;
      next_num_in = next_num_ff;
      tot_a_in = tot_a_ff;
      tot_d_in = tot_d_ff;
      new_id_in = new_id_ff;
      emit_req = 1'b0;
      emit_data = '{event_res: EV_FINISHED, toward: cur_dir, vehicle_id: head.vehicle_id,
                    reported_speed: head.top_speed, direction_count: total_cur,
                    final_item: 1'b0};
      tail = head;
      new_slot = '{used: 1'b1, active: 1'b1, vehicle_id: new_id_ff, cur_speed: spd_ff,
                   top_speed: spd_ff, last_time: now_ff};
      op_a = OP_NOP;
      op_d = OP_NOP;
      match_now = 1'b0;
      out_load = 1'b0;
      out_data = pend_ff;

      case (state_ff)
         ST_IDLE: begin
            res_cnt_in = '0;
            searching_in = 1'b1;
            cnt_in = '0;
            if (req_acc) begin
               now_in = req_data.now_ms;
               spd_in = req_spd;
               dir_in = req_data.approaching;
               if (req_data.kind) state_in = ST_TICKA;
               else if (req_spd >= min_ff) state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (searching_ff && head.used && head.active) begin
               emit_req = 1'b1;
               if (diff > jump_ff || age > tmo_ff) begin
                  tail.active = 1'b0;
               end else begin
                  match_now = 1'b1;
                  emit_data.event_res = EV_SPEED;
                  emit_data.reported_speed = spd_ff;
                  tail.cur_speed = spd_ff;
                  tail.last_time = now_ff;
                  if (spd_ff > head.top_speed) tail.top_speed = spd_ff;
               end
            end
            if (step) begin
               if (dir_ff) op_a = OP_ROT;
               else op_d = OP_ROT;
               if (match_now) searching_in = 1'b0;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  cnt_in = '0;
                  state_in = (searching_ff && !match_now) ? ST_NEWV : ST_FLUSH;
               end
            end
         end
         ST_NEWV: begin
            emit_req = 1'b1;
            emit_data.event_res = EV_NEW;
            emit_data.vehicle_id = next_num_ff;
            emit_data.reported_speed = spd_ff;
            emit_data.direction_count = total_cur + 16'd1;
            if (step) begin
               next_num_in = next_num_ff + 16'd1;
               new_id_in = next_num_ff;
               if (dir_ff) tot_a_in = tot_a_ff + 16'd1;
               else tot_d_in = tot_d_ff + 16'd1;
               state_in = (dir_ff ? full_a : full_d) ? ST_FLUSH : ST_APP;
            end
         end
         ST_APP: begin
            emit_req = 1'b1;
            emit_data.event_res = EV_SPEED;
            emit_data.vehicle_id = new_id_ff;
            emit_data.reported_speed = spd_ff;
            if (step) begin
               if (dir_ff) op_a = OP_APPEND;
               else op_d = OP_APPEND;
               state_in = ST_FLUSH;
            end
         end
         ST_TICKA, ST_TICKD: begin
            if (head.used) begin
               if (head.active && age > tmo_ff) begin
                  emit_req = 1'b1;
                  tail.active = 1'b0;
               end
               if (!tail.active && age > ret_ff) tail.used = 1'b0;
            end
            if (step) begin
               if (cur_dir) op_a = OP_ROT;
               else op_d = OP_ROT;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  cnt_in = '0;
                  state_in = (state_ff == ST_TICKA) ? ST_TICKD : ST_COMPACT;
               end
            end
         end
         ST_COMPACT: begin
            op_a = OP_COMPACT;
            op_d = OP_COMPACT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load = 1'b1;
               out_data.final_item = 1'b1;
               pend_v_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // result staging: the held result leaves once a later one exists
      if (emit_req && step && !drop) begin
         res_cnt_in = res_cnt_ff + 1'b1;
         pend_in = emit_data;
         pend_v_in = 1'b1;
         if (pend_v_ff) begin
            out_load = 1'b1;
            out_data.final_item = 1'b0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in = out_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         searching_ff <= 1'b1;
         res_cnt_ff <= '0;
         pend_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         next_num_ff <= 16'd0;
         tot_a_ff <= 16'd0;
         tot_d_ff <= 16'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         searching_ff <= searching_in;
         res_cnt_ff <= res_cnt_in;
         pend_v_ff <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         next_num_ff <= next_num_in;
         tot_a_ff <= tot_a_in;
         tot_d_ff <= tot_d_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
      now_ff <= now_in;
      spd_ff <= spd_in;
      dir_ff <= dir_in;
      new_id_ff <= new_id_in;
   end

   // checks
   `VTT_ASSERT_IMP(a_idle_nothing_held, clock, reset, state_ff == ST_IDLE, !pend_v_ff, "held")
   `VTT_ASSERT_IMP(a_result_cap, clock, reset, 1'b1, res_cnt_ff <= RES_CAP, "count past cap")
   `VTT_ASSERT_IMP(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall, "taken busy")
   `VTT_ASSERT_NXT(a_match_no_new, clock, reset, state_ff == ST_WALK && !searching_ff, state_ff != ST_NEWV, "new")

endmodule
